@@ design/fqdc_pkg.sv @@
// Package for the factorial quotient divisor count block.
// Holds the prime table, the saturation limit, the divider constants and the sequencer state type.
// No dependencies.
`default_nettype none

package fqdc_pkg;

	// Primes up to 255, tried in ascending order.
	localparam int PRIME_COUNT = 54;

	localparam logic [7:0] PRIMES [PRIME_COUNT] = '{
		8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29,
		8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67, 8'd71,
		8'd73, 8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113,
		8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167,
		8'd173, 8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199, 8'd211, 8'd223,
		8'd227, 8'd229, 8'd233, 8'd239, 8'd241, 8'd251
	};

	// Largest count that the output word carries.
	localparam logic [62:0] SAT_MAX = {63{1'b1}};

	// Divider steps per cycle and cycles per 32-bit division.
	localparam int DIV_STEPS  = 4;
	localparam int DIV_CYCLES = 32 / DIV_STEPS;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_NEXT = 7'b0000010,
		ST_TDIV = 7'b0000100,
		ST_LDIV = 7'b0001000,
		ST_ECHK = 7'b0010000,
		ST_MCHK = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

@@ design/factorial_quotient_divisor_count_top.sv @@
// Each prime up to |n| costs a trial division of m, plus one more per prime factor of m
// and one per further Legendre term; all of them run on the shared divider, which retires
// 4 quotient bits a cycle.
// Throughput: one word at a time; the block is busy from input until its result loads.
// A finished result waits in the output register while the next word is accepted.
// Reset: arst_n clears the sequencer and the output valid at once; no clearing pass.
//
// Top level of the factorial quotient divisor count block.
// Depends on fqdc_pkg.
`default_nettype none

module factorial_quotient_divisor_count_top #(
	parameter int MAX_N = 127
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [7:0]  factorial_base,
	input  wire logic signed [31:0] divisor_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [62:0]             divisor_count
);

	localparam logic [7:0] MaxN = 8'(MAX_N);
	localparam logic [5:0] PrimeLast = 6'(fqdc_pkg::PRIME_COUNT);
	localparam logic [2:0] DivLast = 3'(fqdc_pkg::DIV_CYCLES - 1);

	fqdc_pkg::state_t state_q;

	logic [7:0]  n_q;
	logic [31:0] m_q;
	logic [5:0]  idx_q;
	logic [7:0]  p_q;
	logic [5:0]  mexp_q;
	logic [7:0]  e_q;
	logic [62:0] tot_q;
	logic [70:0] prod_q;
	logic        sat_q;
	logic        zero_q;
	logic [31:0] dq_q;
	logic [7:0]  rem_q;
	logic [2:0]  cnt_q;
	logic        out_valid_q;
	logic [62:0] out_q;

	// Magnitudes of the input word.
	logic [7:0]  n_abs;
	logic [31:0] m_abs;
	assign n_abs = factorial_base[7] ? 8'(-factorial_base) : 8'(factorial_base);
	assign m_abs = divisor_value[31] ? 32'(-divisor_value) : 32'(divisor_value);

	// Prime at the current table position.
	logic [7:0] p_sel;
	assign p_sel = (idx_q < PrimeLast) ? fqdc_pkg::PRIMES[idx_q] : 8'd0;

	// Shared restoring divider: four quotient bits per cycle.
	logic [31:0] dq_nx;
	logic [7:0]  rem_nx;
	always_comb begin
		logic [8:0] r9;
		dq_nx  = dq_q;
		rem_nx = rem_q;
		for (int j = 0; j < fqdc_pkg::DIV_STEPS; j++) begin
			r9    = {rem_nx, dq_nx[31]};
			dq_nx = {dq_nx[30:0], 1'b0};
			if (r9 >= {1'b0, p_q}) begin
				rem_nx   = 8'(r9 - {1'b0, p_q});
				dq_nx[0] = 1'b1;
			end else begin
				rem_nx = r9[7:0];
			end
		end
	end

	logic div_done;
	assign div_done = (cnt_q == DivLast);

	// Exponent arithmetic for the product factor.
	logic [7:0] e_sum;
	logic [7:0] fac;
	assign e_sum = e_q + dq_nx[7:0];
	assign fac   = 8'(e_q - {2'b00, mexp_q} + 8'd1);

	// Final result word.
	logic [62:0] result;
	assign result = (zero_q || (m_q != 32'd1)) ? 63'd0 :
	                sat_q ? fqdc_pkg::SAT_MAX : tot_q;

	// The result loads once the output register is free or being emptied.
	logic load_out;
	assign load_out = (state_q == fqdc_pkg::ST_FIN) && (!out_valid_q || out_ready);

	assign in_ready      = (state_q == fqdc_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign divisor_count = out_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqdc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fqdc_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= fqdc_pkg::ST_NEXT;
					end
				end
				fqdc_pkg::ST_NEXT: begin
					if (idx_q >= PrimeLast || p_sel > n_q || p_sel > MaxN) begin
						state_q <= fqdc_pkg::ST_FIN;
					end else begin
						state_q <= fqdc_pkg::ST_TDIV;
					end
				end
				fqdc_pkg::ST_TDIV: begin
					if (div_done && rem_nx != 8'd0) begin
						state_q <= fqdc_pkg::ST_LDIV;
					end
				end
				fqdc_pkg::ST_LDIV: begin
					if (div_done && dq_nx < {24'd0, p_q}) begin
						state_q <= fqdc_pkg::ST_ECHK;
					end
				end
				fqdc_pkg::ST_ECHK: begin
					if (e_q < {2'b00, mexp_q}) begin
						state_q <= fqdc_pkg::ST_FIN;
					end else begin
						state_q <= fqdc_pkg::ST_MCHK;
					end
				end
				fqdc_pkg::ST_MCHK: begin
					state_q <= fqdc_pkg::ST_NEXT;
				end
				fqdc_pkg::ST_FIN: begin
					if (load_out) begin
						state_q <= fqdc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fqdc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			fqdc_pkg::ST_IDLE: begin
				n_q    <= n_abs;
				m_q    <= (m_abs == 32'd0) ? 32'd1 : m_abs;
				idx_q  <= 6'd0;
				tot_q  <= 63'd1;
				sat_q  <= 1'b0;
				zero_q <= 1'b0;
			end
			fqdc_pkg::ST_NEXT: begin
				// Start trial division of m by the next prime.
				p_q    <= p_sel;
				mexp_q <= 6'd0;
				dq_q   <= m_q;
				rem_q  <= 8'd0;
				cnt_q  <= 3'd0;
			end
			fqdc_pkg::ST_TDIV: begin
				cnt_q <= cnt_q + 3'd1;
				if (div_done) begin
					rem_q <= 8'd0;
					if (rem_nx == 8'd0) begin
						// Prime divides m: keep the quotient and divide again.
						m_q    <= dq_nx;
						mexp_q <= mexp_q + 6'd1;
						dq_q   <= dq_nx;
					end else begin
						// Start the Legendre sum with n.
						dq_q <= {24'd0, n_q};
						e_q  <= 8'd0;
					end
				end else begin
					dq_q  <= dq_nx;
					rem_q <= rem_nx;
				end
			end
			fqdc_pkg::ST_LDIV: begin
				cnt_q <= cnt_q + 3'd1;
				dq_q  <= dq_nx;
				if (div_done) begin
					rem_q <= 8'd0;
					e_q   <= e_sum;
				end else begin
					rem_q <= rem_nx;
				end
			end
			fqdc_pkg::ST_ECHK: begin
				if (e_q < {2'b00, mexp_q}) begin
					zero_q <= 1'b1;
				end
				prod_q <= tot_q * fac;
			end
			fqdc_pkg::ST_MCHK: begin
				if (!sat_q) begin
					if (prod_q > {8'd0, fqdc_pkg::SAT_MAX}) begin
						sat_q <= 1'b1;
					end else begin
						tot_q <= prod_q[62:0];
					end
				end
				idx_q <= idx_q + 6'd1;
			end
			fqdc_pkg::ST_FIN: begin
				if (load_out) begin
					out_q <= result;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/fqdc_checker.sv @@
// Port-level checker for the factorial quotient divisor count block.
// Bound to factorial_quotient_divisor_count_top; no package needed.
`default_nettype none

module fqdc_port_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [62:0] divisor_count
);

	// A waiting result word holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(divisor_count))
		else $error("result word changed while stalled");

	// After a word is accepted the block stays busy and does not take another word at once.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken again too early");

	// A new result only appears at the end of a busy period.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind factorial_quotient_divisor_count_top fqdc_port_props u_fqdc_port_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.divisor_count(divisor_count)
);

`default_nettype wire

@@ test/fqdc_checker.sv @@
// Checker for the factorial quotient divisor count block.
// Watches both channels, predicts each divisor count and compares it.
// Depends on fqdc_pkg for the prime table and the saturation limit.
`default_nettype none

module fqdc_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic signed [7:0]  factorial_base,
	input  wire logic signed [31:0] divisor_value,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [62:0]        divisor_count,
	output int                      fail_count,
	output int                      pending_count,
	output int                      words_in,
	output int                      words_out
);

	localparam int BASE_LIMIT = 127;

	logic [62:0] count_queue [$];

	// Number of divisors of |n|! / |m|, zero when the quotient is not whole.
	function automatic logic [62:0] quotient_divisors(logic [7:0] n_raw, logic [31:0] m_raw);
		int unsigned base_mag;
		logic [32:0] rest;
		logic [63:0] product;
		logic [63:0] factor;
		logic [63:0] power;
		int unsigned legendre;
		int unsigned m_exp [fqdc_pkg::PRIME_COUNT];
		bit saturated;
		int unsigned p;
		base_mag = n_raw[7] ? (256 - n_raw) : n_raw;
		rest = m_raw[31] ? (33'h1_0000_0000 - {1'b0, m_raw}) : {1'b0, m_raw};
		if (rest == 0)
			rest = 1;
		product = 1;
		saturated = 0;
		// Strip every usable prime out of m.
		for (int i = 0; i < fqdc_pkg::PRIME_COUNT; i++) begin
			p = fqdc_pkg::PRIMES[i];
			m_exp[i] = 0;
			if (p > base_mag || p > BASE_LIMIT)
				continue;
			while (rest % p == 0) begin
				rest = rest / p;
				m_exp[i]++;
			end
		end
		if (rest != 1)
			return '0;
		// Multiply the exponent differences plus one, saturating.
		for (int i = 0; i < fqdc_pkg::PRIME_COUNT; i++) begin
			p = fqdc_pkg::PRIMES[i];
			if (p > base_mag || p > BASE_LIMIT)
				continue;
			legendre = 0;
			power = p;
			while (power <= base_mag) begin
				legendre += base_mag / power;
				power = power * p;
			end
			if (legendre < m_exp[i])
				return '0;
			factor = legendre - m_exp[i] + 1;
			if (!saturated) begin
				if (product > {1'b0, fqdc_pkg::SAT_MAX} / factor)
					saturated = 1;
				else
					product = product * factor;
			end
		end
		return saturated ? fqdc_pkg::SAT_MAX : product[62:0];
	endfunction

	assign pending_count = count_queue.size();

	// Predict on each accepted input word, compare on each accepted result word.
	always @(posedge clk or negedge arst_n) begin
		logic [62:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			words_in <= 0;
			words_out <= 0;
			count_queue.delete();
		end else begin
			if (in_valid && in_ready) begin
				count_queue.insert(count_queue.size(),
					quotient_divisors(factorial_base, divisor_value));
				words_in <= words_in + 1;
			end
			if (out_valid && out_ready) begin
				words_out <= words_out + 1;
				if (count_queue.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result word %0d", divisor_count);
					fail_count <= fail_count + 1;
				end else begin
					want = count_queue.pop_front();
					if (want !== divisor_count) begin
						if (fail_count < 10)
							$display("ERROR: divisor_count expected %0d got %0d",
								want, divisor_count);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ test/factorial_quotient_divisor_count_top_tb.sv @@
// Testbench top for the factorial quotient divisor count block.
// Drives directed and random words with random idling and reports the verdict.
// Depends on fqdc_pkg, fqdc_checker and the block itself.
`default_nettype none

module factorial_quotient_divisor_count_top_tb;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [7:0]  factorial_base;
	logic signed [31:0] divisor_value;
	logic               out_valid;
	logic               out_ready;
	logic [62:0]        divisor_count;
	int                 fail_count;
	int                 pending_count;
	int                 words_in;
	int                 words_out;

	// Idle rates in percent, and a long hold on the receiver.
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  recv_hold;

	factorial_quotient_divisor_count_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.factorial_base(factorial_base), .divisor_value(divisor_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.divisor_count(divisor_count)
	);

	fqdc_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.factorial_base(factorial_base), .divisor_value(divisor_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.divisor_count(divisor_count),
		.fail_count(fail_count), .pending_count(pending_count),
		.words_in(words_in), .words_out(words_out)
	);

	// Clock with a 10 unit period.
	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver: random stalls on the falling edge unless a hold is in force.
	always @(negedge clk) begin
		if (recv_hold)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one word and wait for its acceptance.
	task automatic send_word(logic [7:0] n, logic [31:0] m);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_valid = 1;
		factorial_base <= n;
		divisor_value <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		in_valid = 0;
	endtask

	// Product of random small primes up to the base, sometimes scaled by 131 or fully random.
	function automatic logic [31:0] pick_divisor(int unsigned base_mag);
		logic [63:0] m;
		int unsigned p;
		int unsigned terms;
		int unsigned primes [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
		m = 1;
		terms = $urandom_range(12);
		for (int i = 0; i < terms; i++) begin
			p = primes[$urandom_range(9)];
			if (p <= base_mag && m * p < 64'h8000_0000)
				m = m * p;
		end
		case ($urandom_range(9))
			0: m = $urandom;
			1: m = m * 131;
			default: ;
		endcase
		if ($urandom_range(1))
			m = -m;
		return m[31:0];
	endfunction

	// Random words, mostly with divisors built from small primes.
	task automatic send_random(int count);
		int unsigned n;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 7)
				n = $urandom_range(40);
			else
				n = $urandom_range(255);
			send_word(n[7:0], pick_divisor(n[7] ? 256 - n : n));
		end
	endtask

	task automatic wait_drained();
		while (pending_count != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		in_valid = 0;
		factorial_base = 0;
		divisor_value = 0;
		out_ready = 0;
		recv_hold = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes of both fields and the special cases.
		send_word(8'd0, 32'd0);
		send_word(8'd1, 32'd1);
		send_word(8'd1, 32'd2);
		send_word(8'd0, 32'hFFFF_FFFF);
		send_word(8'd5, 32'd0);
		send_word(8'd5, 32'd120);
		send_word(8'd5, 32'd7);
		send_word(8'd10, 32'd1024);
		send_word(8'd10, 32'd256);
		send_word(8'sd127, 32'd0);
		send_word(-8'sd127, 32'd1);
		send_word(8'h80, 32'd0);
		send_word(8'h80, 32'd127);
		send_word(8'h80, 32'd131);
		send_word(8'sd127, 32'h8000_0000);
		send_word(8'sd127, 32'h7FFF_FFFF);
		send_word(8'sd127, 32'hFFFF_FFFF);
		send_word(8'd30, -32'sd30);
		send_word(8'd20, 32'd1_000_000);
		send_word(8'h55, 32'hAAAA_AAAA);
		send_word(8'hAA, 32'h5555_5555);
		wait_drained();

		// Long hold on the receiver while words keep coming.
		fork
			begin
				recv_hold = 1;
				repeat (2000) @(posedge clk);
				recv_hold = 0;
			end
			send_random(10);
		join
		wait_drained();

		send_idle_pct = 16;
		recv_idle_pct = 74;
		send_random(360);
		wait_drained();
		send_idle_pct = 74;
		recv_idle_pct = 16;
		send_random(360);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(360);

		wait_drained();
		repeat (1200) @(posedge clk);
		$display("Covered %0d words in and %0d results out, directed cases, long stall",
			words_in, words_out);
		$display("and three idling profiles with bases up to 128 and all divisor widths.");
		if (fail_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#100000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
design/fqdc_pkg.sv
design/factorial_quotient_divisor_count_top.sv
design/fqdc_checker.sv
test/fqdc_checker.sv
test/factorial_quotient_divisor_count_top_tb.sv
